@@ rtl/bse_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bse_pkg
// Types, constants and the header byte table of the 24-bit BMP stream encoder.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int unsigned SAMPLE_W   = 18;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  // header fields
  localparam logic [15:0] BMP_MAGIC   = 16'h4d42;
  localparam logic [31:0] PIX_OFFSET  = 32'd54;
  localparam logic [31:0] INFO_SIZE   = 32'd40;
  localparam logic [15:0] PLANES      = 16'd1;
  localparam logic [15:0] BIT_COUNT   = 16'd24;
  localparam logic [5:0]  HDR_LAST    = 6'd53;

  localparam logic [16:0] UNIT_ONE    = 17'h10000;
  localparam logic [7:0]  BYTE_FULL   = 8'hff;

  // one classified sample waiting for the back end
  typedef struct packed {
    logic       hdr;
    logic [7:0] data;
    logic [1:0] pad;
    logic       frame_end;
  } entry_t;

  // frame geometry in use
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [31:0]      img_len;
  } geom_t;

  typedef enum logic [1:0] {
    BK_START,
    BK_HEAD,
    BK_DATA,
    BK_PAD
  } bk_state_t;

  // byte idx of the 54-byte little-endian file header
  function automatic logic [7:0] hdr_byte(input logic [5:0] idx, input geom_t g);
    logic [31:0]  fsz;
    logic [31:0]  neg_h;
    logic [431:0] hv;
    logic [8:0]   bit_pos;
    fsz     = PIX_OFFSET + g.img_len;
    neg_h   = 32'd0 - {19'd0, g.height};
    hv      = {128'd0, g.img_len, 32'd0, BIT_COUNT, PLANES, neg_h,
               {19'd0, g.width}, INFO_SIZE, PIX_OFFSET, 32'd0, fsz, BMP_MAGIC};
    bit_pos = {idx, 3'b000};
    return hv[bit_pos +: 8];
  endfunction

endpackage
`default_nettype wire

@@ rtl/bse_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bse channel interfaces
// Valid/ready channels for samples, output bytes and register writes.
// ----------------------------------------------------------------------------
interface bse_in_if;
  import bse_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface bse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       file_end;
  modport source (output valid, output out_byte, output run_last, output file_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input file_end,
                  output ready);
endinterface

interface bse_cfg_if;
  import bse_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/bmp24_stream_encoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_stream_encoder
// Streams a 24-bit top-down BMP file from B,G,R channel samples.
// ----------------------------------------------------------------------------
// Each accepted sample (signed, 16 fraction bits) becomes one byte, clamped to
// 0..255 as floor(255*v). The first sample of a frame is preceded by the
// 54-byte header, and the last sample of each row is followed by 0..3 zero
// pad bytes. The byte sequencer in the back end emits one byte per cycle into
// the output register unless out_ch.ready stalls it; a sample yields one byte,
// plus header bytes at frame start and pad bytes at row end. A four-entry queue
// lets samples keep arriving while header or pad bytes drain. A sample's first
// byte goes through the queue, then the output register. Register writes are
// taken at any time but must only be issued while no bytes are outstanding.
// ----------------------------------------------------------------------------
module bmp24_stream_encoder #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bse_in_if.sink    in_ch,
  bse_out_if.source out_ch,
  bse_cfg_if.sink   cfg_ch
);
  import bse_pkg::*;

  logic   push;
  logic   pop;
  logic   fifo_full;
  logic   fifo_empty;
  entry_t push_entry;
  entry_t head;
  geom_t  geom;

  bse_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .fifo_full  (fifo_full),
    .push       (push),
    .push_entry (push_entry),
    .geom       (geom)
  );

  bse_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (push_entry),
    .full     (fifo_full),
    .pop      (pop),
    .rd_entry (head),
    .empty    (fifo_empty)
  );

  bse_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (fifo_empty),
    .geom   (geom),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // end of file is always the last byte of its sample
  a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.file_end |-> out_ch.run_last)
    else $error("file_end without run_last");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fifo_empty)
    else $error("queue popped while empty");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> in_ch.ready && !fifo_full)
    else $error("sample taken into a full queue");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

@@ rtl/bse_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bse_front
// Holds the registers and frame counters, turns each sample into a byte and
// tags it with header, padding and end-of-frame information.
// ----------------------------------------------------------------------------
module bse_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  bse_in_if.sink             in_ch,
  bse_cfg_if.sink            cfg_ch,
  input  wire logic          fifo_full,
  output logic               push,
  output bse_pkg::entry_t    push_entry,
  output bse_pkg::geom_t     geom
);
  import bse_pkg::*;

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic [DIM_W-1:0] eff_w;
  logic [DIM_W-1:0] eff_h;
  logic [14:0]      row_data;
  logic [1:0]       pad;
  logic [14:0]      row_len;
  logic [27:0]      img_prod;
  logic [31:0]      img_len_r;

  logic             hdr_pend_r;
  logic             hdr_pend_nxt;
  logic [13:0]      col_r;
  logic [13:0]      col_nxt;
  logic [DIM_W-1:0] row_r;
  logic [DIM_W-1:0] row_nxt;

  logic [13:0]      col_inc;
  logic [DIM_W-1:0] row_inc;
  logic             row_end;
  logic             frame_end;
  logic [16:0]      mag;
  logic [24:0]      scaled;
  logic [7:0]       sample_byte;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_ch.data;
        CFG_IMAGE_HEIGHT: height_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // clamp to 1..max, zero acts as one
  always_comb begin
    if (width_r == '0) begin
      eff_w = DIM_W'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      eff_w = DIM_W'(MAX_WIDTH);
    end else begin
      eff_w = width_r;
    end
    if (height_r == '0) begin
      eff_h = DIM_W'(1);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      eff_h = DIM_W'(MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
  end

  assign row_data = {2'b00, eff_w} + {1'b0, eff_w, 1'b0};
  assign pad      = 2'b00 - row_data[1:0];
  assign row_len  = row_data + {13'd0, pad};
  assign img_prod = 28'(row_len) * 28'(eff_h);

  always_ff @(posedge clk) begin
    img_len_r <= {4'd0, img_prod};
  end

  assign geom.width   = eff_w;
  assign geom.height  = eff_h;
  assign geom.img_len = img_len_r;

  // floor(255 * v) with saturation at both ends
  assign mag    = in_ch.sample_value[16:0];
  assign scaled = {mag, 8'd0} - {8'd0, mag};
  always_comb begin
    if (in_ch.sample_value[SAMPLE_W-1]) begin
      sample_byte = 8'd0;
    end else if (in_ch.sample_value[16:0] > UNIT_ONE) begin
      sample_byte = BYTE_FULL;
    end else begin
      sample_byte = scaled[23:16];
    end
  end

  assign in_ch.ready = !fifo_full;
  assign push        = in_ch.valid && !fifo_full;

  assign col_inc   = col_r + 14'd1;
  assign row_inc   = row_r + DIM_W'(1);
  assign row_end   = {1'b0, col_inc} >= row_data;
  assign frame_end = row_end && (row_inc >= eff_h);

  assign push_entry.hdr       = hdr_pend_r;
  assign push_entry.data      = sample_byte;
  assign push_entry.pad       = row_end ? pad : 2'b00;
  assign push_entry.frame_end = frame_end;

  always_comb begin
    hdr_pend_nxt = hdr_pend_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    if (push) begin
      hdr_pend_nxt = frame_end;
      if (frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_inc;
      end else begin
        col_nxt = col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pend_r <= 1'b1;
      col_r      <= '0;
      row_r      <= '0;
    end else begin
      hdr_pend_r <= hdr_pend_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/bse_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bse_fifo
// Short queue of classified samples between the front and the byte sequencer.
// ----------------------------------------------------------------------------
module bse_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire bse_pkg::entry_t wr_entry,
  output logic                 full,
  input  wire logic            pop,
  output bse_pkg::entry_t      rd_entry,
  output logic                 empty
);
  import bse_pkg::*;

  entry_t                mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;

  assign full     = count_r == FIFO_CNT_W'(FIFO_DEPTH);
  assign empty    = count_r == '0;
  assign rd_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + FIFO_CNT_W'(1);
        2'b01:   count_r <= count_r - FIFO_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/bse_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bse_back
// Byte sequencer: expands each queued sample into header, data and pad bytes
// and drives the registered output channel.
// ----------------------------------------------------------------------------
module bse_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bse_pkg::entry_t head,
  input  wire logic            empty,
  input  wire bse_pkg::geom_t  geom,
  output logic                 pop,
  bse_out_if.source            out_ch
);
  import bse_pkg::*;

  bk_state_t  state_r;
  bk_state_t  state_nxt;
  logic [5:0] idx_r;
  logic [5:0] idx_nxt;
  logic [1:0] pad_r;
  logic [1:0] pad_nxt;

  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       fend_r;

  logic       ld;
  logic [5:0] hsel;
  logic [7:0] hbyte;
  logic [7:0] byte_c;
  logic       last_c;
  logic       fend_c;

  assign ld    = !empty && (!out_valid_r || out_ch.ready);
  assign hsel  = (state_r == BK_HEAD) ? idx_r : 6'd0;
  assign hbyte = hdr_byte(hsel, geom);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    pad_nxt   = pad_r;
    pop       = 1'b0;
    byte_c    = 8'd0;
    last_c    = 1'b0;
    fend_c    = 1'b0;
    unique case (state_r) inside
      BK_START, BK_DATA: begin
        if (state_r == BK_START && head.hdr) begin
          byte_c = hbyte;
          if (ld) begin
            state_nxt = BK_HEAD;
            idx_nxt   = 6'd1;
          end
        end else begin
          byte_c = head.data;
          last_c = head.pad == 2'd0;
          fend_c = last_c && head.frame_end;
          if (ld) begin
            if (last_c) begin
              pop       = 1'b1;
              state_nxt = BK_START;
            end else begin
              state_nxt = BK_PAD;
              pad_nxt   = head.pad;
            end
          end
        end
      end
      BK_HEAD: begin
        byte_c = hbyte;
        if (ld) begin
          if (idx_r == HDR_LAST) begin
            state_nxt = BK_DATA;
          end else begin
            idx_nxt = idx_r + 6'd1;
          end
        end
      end
      BK_PAD: begin
        // pad_r counts the zero bytes still owed, this one included
        last_c = pad_r == 2'd1;
        fend_c = last_c && head.frame_end;
        if (ld) begin
          if (last_c) begin
            pop       = 1'b1;
            state_nxt = BK_START;
          end else begin
            pad_nxt = pad_r - 2'd1;
          end
        end
      end
      default: state_nxt = BK_START;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_START;
      idx_r       <= '0;
      pad_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      pad_r   <= pad_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      byte_r <= byte_c;
      last_r <= last_c;
      fend_r <= fend_c;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = byte_r;
  assign out_ch.run_last = last_r;
  assign out_ch.file_end = fend_r;

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Checks the 24-bit BMP stream encoder byte by byte against a predictor.
// Samples go in over the input channel, and every output word is compared with
// the oldest predicted byte (data, run_last, file_end). Directed tests cover
// reset geometry, sample extremes, zero and oversized registers and
// mid-frame register changes. Backpressure and random frames follow.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bse_pkg::*;

  localparam int unsigned FRAME_W_MAX  = 4096;
  localparam int unsigned FRAME_H_MAX  = 4096;
  localparam int          RANDOM_ITEMS = 350;
  localparam int          DRAIN_CYCLES = 4;
  localparam int          QUIET_LIMIT  = 4000;
  localparam int          PRINT_CAP    = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       file_end;
  } bmp_byte_t;

  logic clk;
  logic rst_n;

  bse_in_if  in_if();
  bse_out_if out_if();
  bse_cfg_if cfg_if();

  bmp24_stream_encoder #(
    .MAX_WIDTH (FRAME_W_MAX),
    .MAX_HEIGHT(FRAME_H_MAX)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // predictor state
  logic [DIM_W-1:0] width_reg  = WIDTH_RESET;
  logic [DIM_W-1:0] height_reg = HEIGHT_RESET;
  logic             header_due = 1'b1;
  logic [13:0]      col_bytes  = '0;
  logic [12:0]      rows_done  = '0;

  bmp_byte_t pending_bytes[$];
  bmp_byte_t held_byte;
  bit        held_valid = 1'b0;

  int  err_count    = 0;
  int  bytes_seen   = 0;
  int  samples_sent = 0;
  int  stall_hold   = 0;
  int  quiet_cycles = 0;
  bit  tx_calm      = 1'b0;
  bit  rx_calm      = 1'b0;
  bmp_byte_t want_byte;

  function automatic int next_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int unsigned pick;
    logic signed [SAMPLE_W-1:0] s;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      s = SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
    end else if (pick < 7) begin
      s = SAMPLE_W'($urandom_range(0, 65536));
    end else if (pick == 7) begin
      s = SAMPLE_W'($urandom_range(65530, 65540));
    end else if (pick == 8) begin
      s = -SAMPLE_W'($urandom_range(0, 4));
    end else if ($urandom_range(0, 1) == 1) begin
      s = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      s = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end
    return s;
  endfunction

  // last byte of a sample is held back so its flags can be set
  task automatic emit_byte(input logic [7:0] b);
    if (held_valid) pending_bytes.push_back(held_byte);
    held_byte.data     = b;
    held_byte.run_last = 1'b0;
    held_byte.file_end = 1'b0;
    held_valid         = 1'b1;
  endtask

  task automatic emit_le(input logic [31:0] val, input int nbytes);
    for (int k = 0; k < nbytes; k++) emit_byte(val[8*k +: 8]);
  endtask

  task automatic encode_sample(input logic signed [SAMPLE_W-1:0] v);
    int unsigned w, h, row_data, pad, row_len;
    logic [31:0] img_len;
    logic [31:0] scaled;
    logic [7:0]  b;
    logic        frame_done;
    w = (width_reg == '0) ? 1 : int'(width_reg);
    if (w > FRAME_W_MAX) w = FRAME_W_MAX;
    h = (height_reg == '0) ? 1 : int'(height_reg);
    if (h > FRAME_H_MAX) h = FRAME_H_MAX;
    row_data   = 3 * w;
    pad        = (4 - (row_data & 3)) & 3;
    row_len    = row_data + pad;
    img_len    = row_len * h;
    frame_done = 1'b0;
    if (header_due) begin
      emit_le(32'(BMP_MAGIC), 2);
      emit_le(PIX_OFFSET + img_len, 4);
      emit_le(32'd0, 4);
      emit_le(PIX_OFFSET, 4);
      emit_le(INFO_SIZE, 4);
      emit_le(32'(w), 4);
      emit_le(32'd0 - 32'(h), 4);
      emit_le(32'(PLANES), 2);
      emit_le(32'(BIT_COUNT), 2);
      emit_le(32'd0, 4);
      emit_le(img_len, 4);
      emit_le(32'd0, 4);
      emit_le(32'd0, 4);
      emit_le(32'd0, 4);
      emit_le(32'd0, 4);
      header_due = 1'b0;
    end
    if (v[SAMPLE_W-1]) begin
      b = 8'd0;
    end else if (v[16:0] > UNIT_ONE) begin
      b = BYTE_FULL;
    end else begin
      scaled = 32'(BYTE_FULL) * {15'd0, v[16:0]};
      b      = scaled[23:16];
    end
    emit_byte(b);
    col_bytes = col_bytes + 14'd1;
    if (32'(col_bytes) >= row_data) begin
      for (int k = 0; k < pad; k++) emit_byte(8'd0);
      col_bytes = '0;
      rows_done = rows_done + 13'd1;
      if (32'(rows_done) >= h) begin
        frame_done = 1'b1;
        rows_done  = '0;
        header_due = 1'b1;
      end
    end
    held_byte.run_last = 1'b1;
    held_byte.file_end = frame_done;
    pending_bytes.push_back(held_byte);
    held_valid = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("%0t: byte %0d %s: got %0d, expected %0d", $realtime, bytes_seen, what, got,
               want);
  endtask

  // leaves valid high so back-to-back words stay back to back
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
    int gap;
    gap = next_gap(tx_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.sample_value <= v;
    do @(posedge clk); while (!in_if.ready);
    encode_sample(v);
    samples_sent++;
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic finish_burst();
    in_if.valid <= 1'b0;
    wait_drained();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == CFG_IMAGE_WIDTH) width_reg = value;
    else if (idx == CFG_IMAGE_HEIGHT) height_reg = value;
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // default 640x480 header, then the sample extremes
  task automatic test_reset_geometry();
    send_sample({1'b1, {(SAMPLE_W-1){1'b0}}});
    send_sample({1'b0, {(SAMPLE_W-1){1'b1}}});
    send_sample('0);
    finish_burst();
  endtask

  // zero registers act as one; shrinking mid-row ends row and frame at once
  task automatic test_zero_size_mid_frame();
    write_reg(CFG_IMAGE_WIDTH, '0);
    write_reg(CFG_IMAGE_HEIGHT, '0);
    send_sample(SAMPLE_W'(65536));
    send_sample(SAMPLE_W'(65537));
    send_sample(SAMPLE_W'(65535));
    send_sample(-SAMPLE_W'(1));
    finish_burst();
  endtask

  // two-byte row pad, then height dropped to the rows already done
  task automatic test_row_padding();
    write_reg(CFG_IMAGE_WIDTH, DIM_W'(2));
    write_reg(CFG_IMAGE_HEIGHT, DIM_W'(3));
    for (int i = 0; i < 7; i++) send_sample(SAMPLE_W'(i * 9000 + 1));
    finish_burst();
    write_reg(CFG_IMAGE_HEIGHT, DIM_W'(1));
    for (int i = 0; i < 5; i++) send_sample(SAMPLE_W'(32768 + i));
    finish_burst();
  endtask

  // an oversized width register clamps in the header; height sits at the maximum
  task automatic test_oversize_clamp();
    write_reg(CFG_IMAGE_WIDTH, {DIM_W{1'b1}});
    write_reg(CFG_IMAGE_HEIGHT, DIM_W'(FRAME_H_MAX));
    send_sample(SAMPLE_W'(1));
    finish_burst();
    write_reg(CFG_IMAGE_WIDTH, DIM_W'(1));
    write_reg(CFG_IMAGE_HEIGHT, DIM_W'(1));
    send_sample(SAMPLE_W'(40000));
    send_sample(SAMPLE_W'(20000));
    finish_burst();
  endtask

  // receiver holds off while the sender keeps pushing a whole frame
  task automatic test_output_backpressure();
    write_reg(CFG_IMAGE_WIDTH, DIM_W'(4));
    write_reg(CFG_IMAGE_HEIGHT, DIM_W'(2));
    tx_calm    = 1'b1;
    stall_hold = 80;
    for (int i = 0; i < 24; i++) send_sample(rand_sample());
    tx_calm = 1'b0;
    finish_burst();
  endtask

  task automatic test_random_frames();
    int w, h, n;
    while (samples_sent < RANDOM_ITEMS) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      h = $urandom_range(1, 4);
      if ($urandom_range(0, 11) == 0) w = 0;
      if ($urandom_range(0, 11) == 0) h = 0;
      if ($urandom_range(0, 1) == 1) begin
        write_reg(CFG_IMAGE_WIDTH, DIM_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, DIM_W'(h));
      end else begin
        write_reg(CFG_IMAGE_HEIGHT, DIM_W'(h));
        write_reg(CFG_IMAGE_WIDTH, DIM_W'(w));
      end
      n = 3 * ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      // now and then a cut-off frame, so the next settings land mid-frame
      if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
      for (int i = 0; i < n; i++) send_sample(rand_sample());
      finish_burst();
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.sample_value <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= CFG_IMAGE_WIDTH;
    cfg_if.data        <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_geometry();
    test_zero_size_mid_frame();
    test_row_padding();
    test_oversize_clamp();
    test_output_backpressure();
    test_random_frames();
    finish_burst();
    repeat (16) @(posedge clk);
    if (err_count == 0 && pending_bytes.size() == 0) begin
      $display("bmp24_stream_encoder test passed");
    end else begin
      $display("bmp24_stream_encoder test failed");
    end
    $finish;
  end

  // output ready: random gaps, plus a long hold-off on request
  initial begin
    int gap_left;
    gap_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_hold > 0) begin
        out_if.ready <= 1'b0;
        stall_hold--;
      end else if (gap_left > 0) begin
        out_if.ready <= 1'b0;
        gap_left--;
      end else begin
        out_if.ready <= 1'b1;
        gap_left = next_gap(rx_calm);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected word", int'(out_if.out_byte), -1);
      end else begin
        want_byte = pending_bytes.pop_front();
        if (out_if.out_byte !== want_byte.data)
          report_mismatch("out_byte", int'(out_if.out_byte), int'(want_byte.data));
        if (out_if.run_last !== want_byte.run_last)
          report_mismatch("run_last", int'(out_if.run_last), int'(want_byte.run_last));
        if (out_if.file_end !== want_byte.file_end)
          report_mismatch("file_end", int'(out_if.file_end), int'(want_byte.file_end));
      end
      bytes_seen++;
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("bmp24_stream_encoder test failed");
      $finish;
    end
  end

endmodule

@@ filelist.f @@
rtl/bse_pkg.sv
rtl/bse_if.sv
rtl/bse_front.sv
rtl/bse_fifo.sv
rtl/bse_back.sv
rtl/bmp24_stream_encoder.sv
sim/tb_top.sv
